// File: rtl/core/gds_pkg.sv
package gds_pkg;

  // Request and response payloads
  typedef struct packed {
    logic [3:0]         req_type;
    logic [13:0]        amount;
    logic [4:0]         start_day;
    logic [3:0]         start_month;
    logic signed [15:0] start_year;
  } gds_req_t;

  typedef struct packed {
    logic [4:0]         result_day;
    logic [3:0]         result_month;
    logic signed [15:0] result_year;
    logic               year_underflow;
  } gds_rsp_t;

  // Unit codes carried in req_type
  localparam logic [3:0] UNIT_DAY      = 4'd0;
  localparam logic [3:0] UNIT_WEEK     = 4'd1;
  localparam logic [3:0] UNIT_MONTH    = 4'd2;
  localparam logic [3:0] UNIT_YEAR_STP = 4'd3;
  localparam logic [3:0] UNIT_DEC_STP  = 4'd4;
  localparam logic [3:0] UNIT_YEAR_DIR = 4'd5;
  localparam logic [3:0] UNIT_DEC_DIR  = 4'd6;
  localparam logic [3:0] UNIT_CENTURY  = 4'd7;
  localparam logic [3:0] UNIT_MILLENN  = 4'd8;

  localparam logic [13:0]        MAX_AMOUNT = 14'd9999;
  localparam logic signed [15:0] YEAR_MIN   = 16'sh8000;
  localparam logic signed [24:0] YEAR_MIN_W = 25'sh1FF8000;
  localparam logic [8:0]         R400_LAST  = 9'd399;
  localparam logic [16:0]        R400_DIV   = 17'd400;
  // (y + 32768 + 32) mod 400 == y mod 400
  localparam logic [16:0]        R400_BIAS  = 17'd32;
  // floor(v / 25) == (v * 1311) >> 15 for v up to 4097
  localparam logic [10:0]        RECIP_25   = 11'd1311;

  // Leap test on the year taken mod 400 (0..399)
  function automatic logic is_leap(input logic [8:0] r);
    is_leap = (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
  endfunction

  // Month length, month in 1..12
  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    unique case (m)
      4'd2:                      days_in = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   days_in = 5'd30;
      default:                   days_in = 5'd31;
    endcase
  endfunction

  // Datapath operations selected by the control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MODINIT,
    OP_MODDIV,
    OP_MODREM,
    OP_CLAMPD,
    OP_DAYSTEP,
    OP_MONSTEP,
    OP_YRSTEP,
    OP_DIRSUB,
    OP_FEBCLAMP,
    OP_EMIT
  } gds_op_e;

  // Jump conditions
  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_CNT_MORE,
    COND_T_DAYWK,
    COND_T_MONTH,
    COND_T_YSTEP,
    COND_T_DIRECT,
    COND_OUT_BUSY
  } gds_cond_e;

  typedef logic [4:0] gds_pc_t;

  typedef struct packed {
    gds_op_e   op;
    gds_cond_e cond;
    gds_pc_t   target;
  } gds_uword_t;

  // Program labels
  localparam gds_pc_t PC_IDLE   = 5'd0;
  localparam gds_pc_t PC_MODI0  = 5'd1;
  localparam gds_pc_t PC_MODD0  = 5'd2;
  localparam gds_pc_t PC_MODR0  = 5'd3;
  localparam gds_pc_t PC_CLAMP  = 5'd4;
  localparam gds_pc_t PC_DSP0   = 5'd5;
  localparam gds_pc_t PC_DSP1   = 5'd6;
  localparam gds_pc_t PC_DSP2   = 5'd7;
  localparam gds_pc_t PC_DSP3   = 5'd8;
  localparam gds_pc_t PC_DSP4   = 5'd9;
  localparam gds_pc_t PC_DAY    = 5'd10;
  localparam gds_pc_t PC_DAYX   = 5'd11;
  localparam gds_pc_t PC_MON    = 5'd12;
  localparam gds_pc_t PC_MONX   = 5'd13;
  localparam gds_pc_t PC_YRS    = 5'd14;
  localparam gds_pc_t PC_YRSX   = 5'd15;
  localparam gds_pc_t PC_DIR    = 5'd16;
  localparam gds_pc_t PC_MODI1  = 5'd17;
  localparam gds_pc_t PC_MODD1  = 5'd18;
  localparam gds_pc_t PC_MODR1  = 5'd19;
  localparam gds_pc_t PC_FEB    = 5'd20;
  localparam gds_pc_t PC_EMIT   = 5'd21;
  localparam gds_pc_t PC_BACK   = 5'd22;

  // Control store
  function automatic gds_uword_t ucode_rom(input gds_pc_t pc);
    unique case (pc)
      PC_IDLE:  ucode_rom = '{OP_LOAD,     COND_NO_INPUT, PC_IDLE};
      PC_MODI0: ucode_rom = '{OP_MODINIT,  COND_NEVER,    PC_IDLE};
      PC_MODD0: ucode_rom = '{OP_MODDIV,   COND_NEVER,    PC_IDLE};
      PC_MODR0: ucode_rom = '{OP_MODREM,   COND_NEVER,    PC_IDLE};
      PC_CLAMP: ucode_rom = '{OP_CLAMPD,   COND_NEVER,    PC_IDLE};
      PC_DSP0:  ucode_rom = '{OP_NOP,      COND_T_DAYWK,  PC_DAY};
      PC_DSP1:  ucode_rom = '{OP_NOP,      COND_T_MONTH,  PC_MON};
      PC_DSP2:  ucode_rom = '{OP_NOP,      COND_T_YSTEP,  PC_YRS};
      PC_DSP3:  ucode_rom = '{OP_NOP,      COND_T_DIRECT, PC_DIR};
      PC_DSP4:  ucode_rom = '{OP_NOP,      COND_ALWAYS,   PC_EMIT};
      PC_DAY:   ucode_rom = '{OP_DAYSTEP,  COND_CNT_MORE, PC_DAY};
      PC_DAYX:  ucode_rom = '{OP_NOP,      COND_ALWAYS,   PC_EMIT};
      PC_MON:   ucode_rom = '{OP_MONSTEP,  COND_CNT_MORE, PC_MON};
      PC_MONX:  ucode_rom = '{OP_NOP,      COND_ALWAYS,   PC_EMIT};
      PC_YRS:   ucode_rom = '{OP_YRSTEP,   COND_CNT_MORE, PC_YRS};
      PC_YRSX:  ucode_rom = '{OP_NOP,      COND_ALWAYS,   PC_EMIT};
      PC_DIR:   ucode_rom = '{OP_DIRSUB,   COND_NEVER,    PC_IDLE};
      PC_MODI1: ucode_rom = '{OP_MODINIT,  COND_NEVER,    PC_IDLE};
      PC_MODD1: ucode_rom = '{OP_MODDIV,   COND_NEVER,    PC_IDLE};
      PC_MODR1: ucode_rom = '{OP_MODREM,   COND_NEVER,    PC_IDLE};
      PC_FEB:   ucode_rom = '{OP_FEBCLAMP, COND_NEVER,    PC_IDLE};
      PC_EMIT:  ucode_rom = '{OP_EMIT,     COND_OUT_BUSY, PC_EMIT};
      PC_BACK:  ucode_rom = '{OP_NOP,      COND_ALWAYS,   PC_IDLE};
      default:  ucode_rom = '{OP_NOP,      COND_ALWAYS,   PC_IDLE};
    endcase
  endfunction

endpackage

// File: rtl/core/gregorian_date_subtractor_core.sv
// Channel | Dir | Handshake               | Payload
// --------+-----+-------------------------+------------------------------
// request | in  | in_valid_i/in_ready_o   | in_data_i  (gds_req_t)
// result  | out | out_valid_o/out_ready_i | out_data_o (gds_rsp_t)
//
// A microcoded sequencer runs one request at a time. Every request passes
// load, a three-step mod-400, day clamp, first dispatch, emit and return;
// month and stepwise years pass further dispatch steps, and the step loop
// runs amount times {1,7,1,1,10} steps (up to ~100k for decade steps).
// Direct units subtract once, redo the mod-400 and clamp February; unknown
// units go straight to emit. rst_ni clears pc_q and out_valid_q. A held
// result does not block the next transfer in; only a second result waits.
module gregorian_date_subtractor_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gds_pkg::gds_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gds_pkg::gds_rsp_t out_data_o
);
  import gds_pkg::*;

  // Control
  gds_pc_t    pc_q, pc_d;
  gds_uword_t uw;
  logic       take;
  logic       step_stop;

  // Datapath registers
  logic [3:0]         type_q, type_d;
  logic [4:0]         d_q, d_d;
  logic [3:0]         m_q, m_d;
  logic signed [15:0] y_q, y_d;
  logic [8:0]         r400_q, r400_d;     // year mod 400, kept in step with y
  logic [23:0]        cnt_q, cnt_d;       // amount * unit scale, then loop count
  logic               uf_q, uf_d;
  logic [16:0]        ybias_q, ybias_d;   // year + 32800, same residue mod 400
  logic [7:0]         quo_q, quo_d;       // ybias / 400

  // Output register
  logic     out_valid_q, out_valid_d;
  gds_rsp_t out_data_q, out_data_d;
  logic     out_free;

  // Helpers
  logic [13:0]        amt;
  logic [9:0]         scale;
  logic [3:0]         m_in;
  logic               leap_cur;
  logic [4:0]         dim_cur;
  logic [4:0]         dim_prev;
  logic [8:0]         r400_dec;
  logic [4:0]         feb_dec;
  logic [22:0]        quo_prod;
  logic signed [24:0] y_new;

  assign uw       = ucode_rom(pc_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign leap_cur = is_leap(r400_q);
  assign dim_cur  = days_in(m_q, leap_cur);
  assign dim_prev = days_in(m_q - 4'd1, leap_cur);
  assign r400_dec = (r400_q == 9'd0) ? R400_LAST : r400_q - 9'd1;
  assign feb_dec  = days_in(4'd2, is_leap(r400_dec));
  // (ybias / 16) / 25 by reciprocal, bits 22:15 hold the quotient
  assign quo_prod = 23'(ybias_q[16:4]) * 23'(RECIP_25);
  assign y_new    = {{9{y_q[15]}}, y_q} - $signed({1'b0, cnt_q});

  assign amt  = (in_data_i.amount > MAX_AMOUNT) ? MAX_AMOUNT : in_data_i.amount;
  assign m_in = (in_data_i.start_month == 4'd0) ? 4'd1 :
                (in_data_i.start_month > 4'd12) ? 4'd12 : in_data_i.start_month;

  always_comb begin
    case (in_data_i.req_type)
      UNIT_WEEK:                   scale = 10'd7;
      UNIT_DEC_STP, UNIT_DEC_DIR:  scale = 10'd10;
      UNIT_CENTURY:                scale = 10'd100;
      UNIT_MILLENN:                scale = 10'd1000;
      default:                     scale = 10'd1;
    endcase
  end

  // Datapath, driven by the current control word
  always_comb begin
    type_d      = type_q;
    d_d         = d_q;
    m_d         = m_q;
    y_d         = y_q;
    r400_d      = r400_q;
    cnt_d       = cnt_q;
    uf_d        = uf_q;
    ybias_d     = ybias_q;
    quo_d       = quo_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    step_stop   = 1'b0;

    unique case (uw.op)
      OP_NOP: begin
      end
      OP_LOAD: begin
        if (in_valid_i) begin
          type_d = in_data_i.req_type;
          d_d    = in_data_i.start_day;
          m_d    = m_in;
          y_d    = in_data_i.start_year;
          cnt_d  = 24'(amt) * 24'(scale);
          uf_d   = 1'b0;
        end
      end
      OP_MODINIT: begin
        // offset binary of y plus bias, so the remainder comes out non-negative
        ybias_d = {1'b0, ~y_q[15], y_q[14:0]} + R400_BIAS;
      end
      OP_MODDIV: begin
        quo_d = quo_prod[22:15];
      end
      OP_MODREM: begin
        r400_d = 9'(ybias_q - 17'(quo_q) * R400_DIV);
      end
      OP_CLAMPD: begin
        if (d_q == 5'd0) begin
          d_d = 5'd1;
        end else if (d_q > dim_cur) begin
          d_d = dim_cur;
        end
      end
      OP_DAYSTEP: begin
        if (cnt_q != 24'd0) begin
          cnt_d = cnt_q - 24'd1;
          if (d_q > 5'd1) begin
            d_d = d_q - 5'd1;
          end else if (m_q > 4'd1) begin
            m_d = m_q - 4'd1;
            d_d = dim_prev;
          end else if (y_q != YEAR_MIN) begin
            y_d    = y_q - 16'sd1;
            r400_d = r400_dec;
            m_d    = 4'd12;
            d_d    = 5'd31;
          end else begin
            uf_d      = 1'b1;
            cnt_d     = 24'd0;
            step_stop = 1'b1;
          end
        end
      end
      OP_MONSTEP: begin
        if (cnt_q != 24'd0) begin
          cnt_d = cnt_q - 24'd1;
          if (m_q > 4'd1) begin
            m_d = m_q - 4'd1;
            if (d_q > dim_prev) d_d = dim_prev;
          end else if (y_q != YEAR_MIN) begin
            // December is 31 days, no clamp needed
            y_d    = y_q - 16'sd1;
            r400_d = r400_dec;
            m_d    = 4'd12;
          end else begin
            d_d       = 5'd1;
            m_d       = 4'd1;
            uf_d      = 1'b1;
            cnt_d     = 24'd0;
            step_stop = 1'b1;
          end
        end
      end
      OP_YRSTEP: begin
        if (cnt_q != 24'd0) begin
          cnt_d = cnt_q - 24'd1;
          if (y_q != YEAR_MIN) begin
            y_d    = y_q - 16'sd1;
            r400_d = r400_dec;
            if ((m_q == 4'd2) && (d_q > feb_dec)) d_d = feb_dec;
          end else begin
            uf_d      = 1'b1;
            cnt_d     = 24'd0;
            step_stop = 1'b1;
          end
        end
      end
      OP_DIRSUB: begin
        if (y_new < YEAR_MIN_W) begin
          y_d  = YEAR_MIN;
          uf_d = 1'b1;
        end else begin
          y_d = y_new[15:0];
        end
      end
      OP_FEBCLAMP: begin
        if ((m_q == 4'd2) && (d_q > dim_cur)) d_d = dim_cur;
      end
      OP_EMIT: begin
        if (out_free) begin
          out_data_d.result_day     = d_q;
          out_data_d.result_month   = m_q;
          out_data_d.result_year    = y_q;
          out_data_d.year_underflow = uf_q;
          out_valid_d               = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Jump condition and next step
  always_comb begin
    unique case (uw.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_INPUT: take = !in_valid_i;
      COND_CNT_MORE: take = (cnt_q > 24'd1) && !step_stop;
      COND_T_DAYWK:  take = (type_q == UNIT_DAY) || (type_q == UNIT_WEEK);
      COND_T_MONTH:  take = (type_q == UNIT_MONTH);
      COND_T_YSTEP:  take = (type_q == UNIT_YEAR_STP) || (type_q == UNIT_DEC_STP);
      COND_T_DIRECT: take = (type_q == UNIT_YEAR_DIR) || (type_q == UNIT_DEC_DIR) ||
                            (type_q == UNIT_CENTURY)  || (type_q == UNIT_MILLENN);
      COND_OUT_BUSY: take = !out_free;
      default:       take = 1'b0;
    endcase
    pc_d = take ? uw.target : pc_q + 5'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q     <= type_d;
    d_q        <= d_d;
    m_q        <= m_d;
    y_q        <= y_d;
    r400_q     <= r400_d;
    cnt_q      <= cnt_d;
    uf_q       <= uf_d;
    ybias_q    <= ybias_d;
    quo_q      <= quo_d;
    out_data_q <= out_data_d;
  end

  assign in_ready_o  = (pc_q == PC_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: bench/date_check.sv
module date_check (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  gds_pkg::gds_req_t in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  gds_pkg::gds_rsp_t out_data_i,
  output int                due_cnt_o,
  output int                bad_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import gds_pkg::*;

  localparam int YearFloor = -32768;

  // dates still owed by the block, oldest first
  gds_rsp_t due_dates[$];

  function automatic bit leap_year(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_days(input int m, input int y);
    case (m)
      2:          return leap_year(y) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:    return 31;
    endcase
  endfunction

  // date moved back by the requested amount of units
  function automatic gds_rsp_t date_back(input gds_req_t rq);
    int n, d, m, y, steps, k, ny, i;
    bit uf;
    gds_rsp_t r;
    n  = int'(rq.amount);
    d  = int'(rq.start_day);
    m  = int'(rq.start_month);
    y  = int'($signed(rq.start_year));
    uf = 1'b0;
    if (n > int'(MAX_AMOUNT)) n = int'(MAX_AMOUNT);
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    if (d < 1) d = 1;
    if (d > month_days(m, y)) d = month_days(m, y);

    case (rq.req_type)
      UNIT_DAY, UNIT_WEEK: begin
        steps = (rq.req_type == UNIT_WEEK) ? n * 7 : n;
        for (i = 0; i < steps; i++) begin
          if (d > 1) begin
            d--;
          end else if (m > 1) begin
            m--;
            d = month_days(m, y);
          end else if (y > YearFloor) begin
            y--;
            m = 12;
            d = 31;
          end else begin
            uf = 1'b1;
            break;
          end
        end
      end
      UNIT_MONTH: begin
        for (i = 0; i < n; i++) begin
          if (m > 1) begin
            m--;
          end else if (y > YearFloor) begin
            y--;
            m = 12;
          end else begin
            d  = 1;
            m  = 1;
            uf = 1'b1;
            break;
          end
          if (d > month_days(m, y)) d = month_days(m, y);
        end
      end
      UNIT_YEAR_STP, UNIT_DEC_STP: begin
        steps = (rq.req_type == UNIT_DEC_STP) ? n * 10 : n;
        for (i = 0; i < steps; i++) begin
          if (y > YearFloor) begin
            y--;
          end else begin
            uf = 1'b1;
            break;
          end
          if (m == 2 && d > month_days(m, y)) d = month_days(m, y);
        end
      end
      UNIT_YEAR_DIR, UNIT_DEC_DIR, UNIT_CENTURY, UNIT_MILLENN: begin
        case (rq.req_type)
          UNIT_YEAR_DIR: k = 1;
          UNIT_DEC_DIR:  k = 10;
          UNIT_CENTURY:  k = 100;
          default:       k = 1000;
        endcase
        ny = y - n * k;
        if (ny < YearFloor) begin
          ny = YearFloor;
          uf = 1'b1;
        end
        y = ny;
        if (m == 2 && d > month_days(m, y)) d = month_days(m, y);
      end
      default: ;  // unknown unit: sanitized start date
    endcase

    r.result_day     = d[4:0];
    r.result_month   = m[3:0];
    r.result_year    = y[15:0];
    r.year_underflow = uf;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    gds_rsp_t want;
    if (!rst_ni) begin
      due_dates.delete();
      due_cnt_o = 0;
      bad_cnt_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) due_dates.push_back(date_back(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (due_dates.size() == 0) begin
          $display("%0t: result with none pending: %0d/%0d/%0d uf=%0b", $time,
                   out_data_i.result_day, out_data_i.result_month,
                   $signed(out_data_i.result_year), out_data_i.year_underflow);
          bad_cnt_o++;
        end else begin
          want = due_dates.pop_front();
          if (out_data_i.result_day     !== want.result_day     ||
              out_data_i.result_month   !== want.result_month   ||
              out_data_i.result_year    !== want.result_year    ||
              out_data_i.year_underflow !== want.year_underflow) begin
            $display("%0t: expected %0d/%0d/%0d uf=%0b, got %0d/%0d/%0d uf=%0b", $time,
                     want.result_day, want.result_month, $signed(want.result_year),
                     want.year_underflow, out_data_i.result_day,
                     out_data_i.result_month, $signed(out_data_i.result_year),
                     out_data_i.year_underflow);
            bad_cnt_o++;
          end
        end
      end
      due_cnt_o = due_dates.size();
    end
  end

endmodule

// File: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gds_pkg::*;

  // Longest stretch with no transfer on either side: a decade-step request
  // clamped to the maximum amount, plus the longest sender gap and receiver
  // stall. Taken several times over.
  localparam int IdleLimit   = 500_000;
  localparam int RandomItems = 100;
  // settle time after the last result
  localparam int SettleCycles = 60;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  gds_req_t in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  gds_rsp_t out_data_o;

  int due_cnt;
  int bad_cnt;

  // while set, neither side inserts gaps or stalls
  bit quiet_phase;

  gregorian_date_subtractor_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  date_check u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .due_cnt_o   (due_cnt),
    .bad_cnt_o   (bad_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  function automatic gds_req_t mk_req(input logic [3:0] unit, input int amt, input int d,
                                      input int m, input int y);
    gds_req_t rq;
    rq.req_type    = unit;
    rq.amount      = amt[13:0];
    rq.start_day   = d[4:0];
    rq.start_month = m[3:0];
    rq.start_year  = y[15:0];
    return rq;
  endfunction

  // Random request. Years cluster at both ends of the range, around zero and
  // on century marks; stepwise units mostly get small amounts so the run
  // stays short, with a rare full-range amount.
  function automatic gds_req_t rand_req();
    int r, unit, amt, d, m, y;
    r = $urandom_range(0, 99);
    unit = (r < 85) ? $urandom_range(0, 8) : $urandom_range(9, 15);

    r = $urandom_range(0, 99);
    if (unit >= 5 && unit <= 8) begin
      if (r < 40)      amt = $urandom_range(0, 50);
      else if (r < 80) amt = $urandom_range(0, 9999);
      else             amt = $urandom_range(0, 16383);
    end else begin
      if (r < 4)       amt = $urandom_range(0, 16383);
      else if (r < 20) amt = $urandom_range(41, 400);
      else             amt = $urandom_range(0, 40);
    end

    r = $urandom_range(0, 99);
    if (r < 25)      y = int'($urandom_range(0, 3)) - 32768;
    else if (r < 35) y = 32767 - int'($urandom_range(0, 3));
    else if (r < 55) y = int'($urandom_range(0, 1000)) - 500;
    else if (r < 65) y = (int'($urandom_range(0, 40)) - 20) * 100;
    else             y = int'($signed(16'($urandom)));

    r = $urandom_range(0, 99);
    if (r < 20) begin
      // out-of-range day and month
      d = $urandom_range(0, 31);
      m = $urandom_range(0, 15);
    end else if (r < 32) begin
      // leap day, on a year that may or may not be leap
      d = 29;
      m = 2;
      if ($urandom_range(0, 1)) y = y & ~3;
    end else begin
      m = $urandom_range(1, 12);
      d = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 28) : $urandom_range(29, 31);
    end

    // early in the lowest years, so day and week steps run into the floor
    if (y <= -32765 && $urandom_range(0, 1)) begin
      m = 1;
      d = $urandom_range(1, 5);
    end
    return mk_req(unit[3:0], amt, d, m, y);
  endfunction

  // Quiet stretches come and go; toggled on the rising edge, read on the falling.
  initial begin
    quiet_phase = 1'b0;
    forever begin
      repeat ($urandom_range(100, 1500)) @(posedge clk_i);
      quiet_phase = ~quiet_phase;
    end
  end

  // Result side: ready drops for random stalls.
  initial begin
    int stall_left;
    out_ready_i = 1'b0;
    stall_left  = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Watchdog: ends the run when nothing transfers for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Request side: directed cases, then random ones.
  initial begin
    gds_req_t cases[$];
    gds_req_t rq;
    int gap, total, idx;
    bit hold;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;

    // start date returned as is, plain borrows, leap rules
    cases.push_back(mk_req(UNIT_DAY,      0,     15, 6,  2024));
    cases.push_back(mk_req(UNIT_DAY,      1,     1,  1,  2000));
    cases.push_back(mk_req(UNIT_DAY,      1,     1,  3,  2000));
    cases.push_back(mk_req(UNIT_DAY,      1,     1,  3,  1900));
    // largest amounts, from the top of the year range and from year zero
    cases.push_back(mk_req(UNIT_DAY,      9999,  31, 12, 32767));
    cases.push_back(mk_req(UNIT_WEEK,     9999,  1,  1,  0));
    // date stepping below the lowest year saturates, and a month step clamps the day
    cases.push_back(mk_req(UNIT_DAY,      1,     1,  1,  -32768));
    cases.push_back(mk_req(UNIT_MONTH,    1,     31, 3,  2023));
    cases.push_back(mk_req(UNIT_MONTH,    9999,  15, 1,  -32768));
    // amount above the maximum is clamped
    cases.push_back(mk_req(UNIT_MONTH,    16383, 31, 12, 32767));
    // leap day through stepwise years stays clamped at 28
    cases.push_back(mk_req(UNIT_YEAR_STP, 1,     29, 2,  2024));
    cases.push_back(mk_req(UNIT_YEAR_STP, 4,     29, 2,  2024));
    cases.push_back(mk_req(UNIT_YEAR_STP, 3,     29, 2,  -32767));
    cases.push_back(mk_req(UNIT_DEC_STP,  9999,  29, 2,  32767));
    // direct subtraction clamps February once
    cases.push_back(mk_req(UNIT_YEAR_DIR, 4,     29, 2,  2024));
    cases.push_back(mk_req(UNIT_YEAR_DIR, 1,     29, 2,  2024));
    cases.push_back(mk_req(UNIT_DEC_DIR,  9999,  1,  6,  0));
    cases.push_back(mk_req(UNIT_CENTURY,  100,   29, 2,  2000));
    cases.push_back(mk_req(UNIT_MILLENN,  16383, 10, 10, 32767));
    cases.push_back(mk_req(UNIT_MILLENN,  32,    29, 2,  32767));
    // unknown units and out-of-range day and month
    cases.push_back(mk_req(4'd9,          0,     0,  0,  -1));
    cases.push_back(mk_req(4'd15,         5,     31, 15, 12345));
    cases.push_back(mk_req(UNIT_DAY,      0,     31, 4,  2021));
    cases.push_back(mk_req(UNIT_MONTH,    2,     31, 13, 2023));
    cases.push_back(mk_req(UNIT_YEAR_DIR, 0,     29, 2,  2023));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    total = cases.size() + RandomItems;
    for (idx = 0; idx < total; idx++) begin
      rq = (idx < cases.size()) ? cases[idx] : rand_req();
      // let the block drain completely after the directed part and mid-way
      hold = (idx == cases.size()) || (idx == cases.size() + RandomItems / 2);
      gap  = pick_gap();
      if (hold && gap == 0) gap = 1;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
        if (hold) begin
          while (due_cnt != 0) @(negedge clk_i);
        end
      end
      in_valid_i <= 1'b1;
      in_data_i  <= rq;
      do @(posedge clk_i); while (!in_ready_o);
      @(negedge clk_i);
    end
    in_valid_i <= 1'b0;

    // wait for every owed result, then a little longer for strays
    while (due_cnt != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);

    if (bad_cnt == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
